[rtl/coo_spmv_pkg.sv]
// ----------------------------------------------------------------------------
// coo_spmv_pkg
// Shared types, codes and sizes of the coordinate-format sparse matrix times
// dense vector block.
// ----------------------------------------------------------------------------
package coo_spmv_pkg;

   // storage depths
   localparam int MAX_ROWS = 1024;
   localparam int MAX_COLS = 1024;
   localparam int ROW_AW   = $clog2(MAX_ROWS);
   localparam int COL_AW   = $clog2(MAX_COLS);

   // field and register widths
   localparam int IDX_W    = 10;
   localparam int SIZE_W   = 11;
   localparam int VAL_W    = 32;
   localparam int ACC_W    = 64;
   localparam int ACT_W    = 2;
   localparam int STAT_W   = 2;
   localparam int APB_AW   = 3;
   localparam int APB_DW   = 32;

   localparam logic [SIZE_W-1:0] MAX_ROWS_SZ = SIZE_W'(MAX_ROWS);
   localparam logic [SIZE_W-1:0] MAX_COLS_SZ = SIZE_W'(MAX_COLS);
   localparam logic [SIZE_W-1:0] SIZE_RESET  = 11'd1024;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // input action codes
   typedef enum logic [ACT_W-1:0] {
      ACT_LOAD  = 2'd0,
      ACT_ACCUM = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_SAT   = 2'd2
   } status_type;

   // register indexes, taken from byte address bit 2
   typedef enum logic {
      REG_ACTIVE_ROWS = 1'b0,
      REG_ACTIVE_COLS = 1'b1
   } reg_index_type;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_DONE
   } state_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic [SIZE_W-1:0] active_rows;
      logic [SIZE_W-1:0] active_cols;
   } cfg_type;

   // controller to datapath commands
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic read;
      logic mul;
      logic finish;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } stat_type;

endpackage

[rtl/coo_spmv_ram.sv]
// ----------------------------------------------------------------------------
// coo_spmv_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while the read is not enabled.
// ----------------------------------------------------------------------------
module coo_spmv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/coo_spmv_csr.sv]
// ----------------------------------------------------------------------------
// coo_spmv_csr
// APB-style register file holding the active row and column counts.
// ----------------------------------------------------------------------------
module coo_spmv_csr
   import coo_spmv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [APB_AW-1:0] paddr,
   input  logic [APB_DW-1:0] pwdata,
   output logic [APB_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   logic [SIZE_W-1:0] rows_ff, rows_in;
   logic [SIZE_W-1:0] cols_ff, cols_in;
   logic              wr_word;
   reg_index_type     reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[2]);
   assign wr_word = psel && penable && pwrite && pready;

   // register write decode
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (wr_word) begin
         case (reg_sel)
            REG_ACTIVE_ROWS: rows_in = pwdata[SIZE_W-1:0];
            REG_ACTIVE_COLS: cols_in = pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= SIZE_RESET;
         cols_ff <= SIZE_RESET;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         REG_ACTIVE_ROWS: prdata = APB_DW'(rows_ff);
         REG_ACTIVE_COLS: prdata = APB_DW'(cols_ff);
         default:         prdata = '0;
      endcase
   end

   assign cfg.active_rows = rows_ff;
   assign cfg.active_cols = cols_ff;

endmodule

[rtl/coo_spmv_ctrl.sv]
// ----------------------------------------------------------------------------
// coo_spmv_ctrl
// Controller: clearing pass after reset, then one word at a time through
// accept, memory read, multiply and finish.
// ----------------------------------------------------------------------------
module coo_spmv_ctrl
   import coo_spmv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  stat_type stat,
   output logic     req_stall,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait for the output register to have room
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

[rtl/coo_spmv_datapath.sv]
// ----------------------------------------------------------------------------
// coo_spmv_datapath
// Item registers, range checks, vector and accumulator memories, multiplier,
// saturating accumulate and the output register.
// ----------------------------------------------------------------------------
module coo_spmv_datapath
   import coo_spmv_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   input  cfg_type                  cfg,
   input  logic [ACT_W-1:0]         req_action,
   input  logic [IDX_W-1:0]         req_row_index,
   input  logic [IDX_W-1:0]         req_col_index,
   input  logic signed [VAL_W-1:0]  req_data_value,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic signed [ACC_W-1:0]  rsp_result_value,
   output logic [STAT_W-1:0]        rsp_status,
   output stat_type                 stat
);

   action_type               action_ff;
   logic [IDX_W-1:0]         row_ff;
   logic [IDX_W-1:0]         col_ff;
   logic signed [VAL_W-1:0]  data_ff;
   logic                     row_ok_ff;
   logic                     col_ok_ff;
   logic signed [ACC_W-1:0]  prod_ff;
   logic [ROW_AW-1:0]        clr_cnt_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [ACC_W-1:0]  result_ff, result_in;
   status_type               status_ff, status_in;

   logic [SIZE_W-1:0]        eff_rows;
   logic [SIZE_W-1:0]        eff_cols;
   logic [VAL_W-1:0]         vec_rd_data;
   logic [ACC_W-1:0]         acc_rd_data;
   logic signed [VAL_W-1:0]  vec_value;
   logic signed [ACC_W-1:0]  acc_value;
   logic signed [ACC_W-1:0]  sum;
   logic                     ovf;
   logic signed [ACC_W-1:0]  sat_value;
   logic                     vec_wr_en;
   logic                     acc_wr_en;
   logic [ROW_AW-1:0]        acc_wr_addr;
   logic [ACC_W-1:0]         acc_wr_data;

   // effective sizes, clamped to the storage depth
   assign eff_rows = (cfg.active_rows > MAX_ROWS_SZ) ? MAX_ROWS_SZ : cfg.active_rows;
   assign eff_cols = (cfg.active_cols > MAX_COLS_SZ) ? MAX_COLS_SZ : cfg.active_cols;

   // capture the accepted word and its range flags
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff <= action_type'(req_action);
         row_ff    <= req_row_index;
         col_ff    <= req_col_index;
         data_ff   <= req_data_value;
         row_ok_ff <= SIZE_W'(req_row_index) < eff_rows;
         col_ok_ff <= SIZE_W'(req_col_index) < eff_cols;
      end
   end

   // clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   assign stat.clear_last = (clr_cnt_ff == ROW_AW'(MAX_ROWS - 1));
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   // multiply matrix entry by vector element, sign-extended operands
   assign vec_value = $signed(vec_rd_data);

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= ACC_W'(data_ff) * ACC_W'(vec_value);
      end
   end

   // saturating accumulate
   assign acc_value = $signed(acc_rd_data);
   assign sum       = acc_value + prod_ff;
   assign ovf       = (acc_value[ACC_W-1] == prod_ff[ACC_W-1])
                   && (sum[ACC_W-1] != acc_value[ACC_W-1]);
   assign sat_value = ovf ? (prod_ff[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum;

   // memory writes and the result of the word
   always_comb begin
      vec_wr_en   = 1'b0;
      acc_wr_en   = 1'b0;
      acc_wr_addr = ROW_AW'(row_ff);
      acc_wr_data = '0;
      result_in   = '0;
      status_in   = STAT_OK;
      if (cmd.clear_step) begin
         acc_wr_en   = 1'b1;
         acc_wr_addr = clr_cnt_ff;
      end else if (cmd.finish) begin
         case (action_ff)
            ACT_LOAD: begin
               if (col_ok_ff) begin
                  vec_wr_en = 1'b1;
               end else begin
                  status_in = STAT_RANGE;
               end
            end
            ACT_ACCUM: begin
               if (row_ok_ff && col_ok_ff) begin
                  acc_wr_en   = 1'b1;
                  acc_wr_data = sat_value;
                  if (ovf) begin
                     status_in = STAT_SAT;
                  end
               end else begin
                  status_in = STAT_RANGE;
               end
            end
            ACT_READ: begin
               if (row_ok_ff) begin
                  acc_wr_en = 1'b1;
                  result_in = acc_value;
               end else begin
                  status_in = STAT_RANGE;
               end
            end
            default: ;
         endcase
      end
   end

   coo_spmv_ram #(
      .WIDTH (VAL_W),
      .DEPTH (MAX_COLS)
   ) u_vec_ram (
      .clock   (clock),
      .wr_en   (vec_wr_en),
      .wr_addr (COL_AW'(col_ff)),
      .wr_data (data_ff),
      .rd_en   (cmd.read),
      .rd_addr (COL_AW'(col_ff)),
      .rd_data (vec_rd_data)
   );

   coo_spmv_ram #(
      .WIDTH (ACC_W),
      .DEPTH (MAX_ROWS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_wr_en),
      .wr_addr (acc_wr_addr),
      .wr_data (acc_wr_data),
      .rd_en   (cmd.read),
      .rd_addr (ROW_AW'(row_ff)),
      .rd_data (acc_rd_data)
   );

   // output register
   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         result_ff <= result_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = result_ff;
   assign rsp_status       = status_ff;

endmodule

[rtl/coo_sparse_matrix_vector_multiply_top.sv]
// ----------------------------------------------------------------------------
// coo_sparse_matrix_vector_multiply_top
// Sparse matrix (coordinate triples) times dense vector with Q32.32
// saturating row accumulators, read-and-clear of row results.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  action, row, col, data value
//   rsp      out        rsp_valid/rsp_stall  result value, status
//   csr      in         psel/penable/pready  active_rows (0x0), active_cols (0x4)
//
// Each word passes through accept, memory read, multiply and finish.
// Finish waits while the output register holds an untaken word; the next
// word may be accepted while a result waits.
// After reset a clearing pass zeroes every accumulator memory word; req_stall
// stays high during it, register writes are taken.
// ----------------------------------------------------------------------------
module coo_sparse_matrix_vector_multiply_top
   import coo_spmv_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ACT_W-1:0]         req_action,
   input  logic [IDX_W-1:0]         req_row_index,
   input  logic [IDX_W-1:0]         req_col_index,
   input  logic signed [VAL_W-1:0]  req_data_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [ACC_W-1:0]  rsp_result_value,
   output logic [STAT_W-1:0]        rsp_status,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [APB_AW-1:0]        paddr,
   input  logic [APB_DW-1:0]        pwdata,
   output logic [APB_DW-1:0]        prdata,
   output logic                     pready
);

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   // configuration registers
   coo_spmv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencing
   coo_spmv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // storage and arithmetic
   coo_spmv_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cfg              (cfg),
      .req_action       (req_action),
      .req_row_index    (req_row_index),
      .req_col_index    (req_col_index),
      .req_data_value   (req_data_value),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .stat             (stat)
   );

endmodule

[rtl/coo_spmv_checker.sv]
// ----------------------------------------------------------------------------
// coo_spmv_checker
// Port-level checks of the sparse matrix vector block, bound to the top.
// ----------------------------------------------------------------------------
module coo_spmv_checker
   import coo_spmv_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_stall,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [ACC_W-1:0]  rsp_result_value,
   input  logic [STAT_W-1:0]        rsp_status
);

   // only defined status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_OK || rsp_status == STAT_RANGE
                     || rsp_status == STAT_SAT))
      else $error("undefined status code on rsp");

   // an error or saturated word carries a zero value
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |-> (rsp_result_value == '0))
      else $error("nonzero result with error status");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_result_value)
                                    && $stable(rsp_status)))
      else $error("rsp word changed while stalled");

   // the clearing pass blocks input right after reset
   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("input taken during clearing pass");

endmodule

bind coo_sparse_matrix_vector_multiply_top coo_spmv_checker u_checker (.*);
